/* design/gis_pkg.sv */
// Package for the grayscale image statistics block.
// Holds the frame limits, field widths, register indexes and derived sizes.
// No dependencies; every other design file uses it by scoped names.
package gis_pkg;

    // Frame limits
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;

    // Field widths
    localparam int PIX_W     = 8;
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 2;
    localparam int FRAC_W    = 16;
    localparam int CON_Q_W   = FRAC_W + 1;

    localparam logic [PIX_W-1:0] PIX_FULL = {PIX_W{1'b1}};

    // Pixel count and sum sizes follow from the largest frame
    localparam int MAX_PIXELS = MAX_WIDTH * MAX_HEIGHT;
    localparam int CNT_W      = $clog2(MAX_PIXELS + 1);
    localparam int SUM_W      = $clog2(MAX_PIXELS * 255 + 1);
    localparam int FRAME_W    = 2 * CFG_W;
    localparam int CMP_W      = (FRAME_W > CNT_W) ? FRAME_W : CNT_W;

    // Shared divider: remainder and shifted divisor width
    localparam int DEN_W      = PIX_W + 1;
    localparam int MEAN_DVS_W = CNT_W + PIX_W;
    localparam int CON_DVS_W  = DEN_W + FRAC_W;
    localparam int DIV_W      = (MEAN_DVS_W > CON_DVS_W) ?
                                ((MEAN_DVS_W > SUM_W) ? MEAN_DVS_W : SUM_W) :
                                ((CON_DVS_W > SUM_W) ? CON_DVS_W : SUM_W);
    localparam int CON_STEPS  = CON_Q_W;
    localparam int STEP_W     = $clog2(CON_STEPS);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_HEIGHT = 2'd1;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_MEAN = 4'b0010,
        ST_CON  = 4'b0100,
        ST_DONE = 4'b1000
    } t_state;

endpackage

/* design/gis_pix_if.sv */
// Pixel stream channel: valid/ready handshake with one grayscale pixel.
// Depends on gis_pkg for the pixel width.
interface gis_pix_if;
    logic                      valid;
    logic                      ready;
    logic [gis_pkg::PIX_W-1:0] pixel;

    modport source (output valid, output pixel, input ready);
    modport sink   (input valid, input pixel, output ready);
endinterface

/* design/gis_res_if.sv */
// Frame result channel: valid/ready handshake with the frame statistics.
// Depends on gis_pkg for the field widths.
interface gis_res_if;
    logic                        valid;
    logic                        ready;
    logic [gis_pkg::PIX_W-1:0]   mean_level;
    logic [gis_pkg::PIX_W-1:0]   min_level;
    logic [gis_pkg::PIX_W-1:0]   max_level;
    logic [gis_pkg::CON_Q_W-1:0] contrast_q16;
    logic                        contrast_undefined;

    modport source (output valid, output mean_level, output min_level, output max_level,
                    output contrast_q16, output contrast_undefined, input ready);
    modport sink   (input valid, input mean_level, input min_level, input max_level,
                    input contrast_q16, input contrast_undefined, output ready);
endinterface

/* design/grayscale_image_statistics.sv */
// Grayscale image statistics: running sum/min/max/count, per-frame mean and
// Michelson contrast through one shared restoring divider.
// Depends on gis_pkg, gis_pix_if and gis_res_if.
//
//  Channel   Direction  Handshake            Content
//  i_pix     in         valid/ready          pixel
//  o_res     out        valid/ready          mean, min, max, contrast_q16, undefined
//  i_cfg_*   in         write enable only    index 0 width, index 1 height
//
// An ordinary pixel is taken while the sequencer is idle. The last pixel of a frame starts
// the shared compare/subtract unit: first the mean, then the contrast
// (skipped for an all-black frame), then the load of the result register,
// so i_pix.ready stays low from that transfer until the load.
// The load waits, and ready stays low, while the previous result is still unread.
// The result register holds a finished frame while the next pixels are taken.
// Reset is synchronous, active low; it sets both dimensions to 1 and clears stats.
module grayscale_image_statistics (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    gis_pix_if.sink                         i_pix,
    gis_res_if.source                       o_res,
    input  logic                            i_cfg_we,
    input  logic [gis_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [gis_pkg::CFG_W-1:0]       i_cfg_data
);

    // Zero reads as one, oversize saturates at the limit
    function automatic logic [gis_pkg::CFG_W-1:0] clamp_dim(
        input logic [gis_pkg::CFG_W-1:0] v,
        input int                        limit
    );
        logic [gis_pkg::CFG_W-1:0] res;
        res = v;
        if (v == '0) begin
            res = gis_pkg::CFG_W'(1);
        end else if (32'(v) > 32'(limit)) begin
            res = gis_pkg::CFG_W'(limit);
        end
        return res;
    endfunction

    gis_pkg::t_state r_state, n_state;

    logic [gis_pkg::CFG_W-1:0]   r_width,  n_width;
    logic [gis_pkg::CFG_W-1:0]   r_height, n_height;

    logic [gis_pkg::SUM_W-1:0]   r_sum,   n_sum;
    logic [gis_pkg::PIX_W-1:0]   r_min,   n_min;
    logic [gis_pkg::PIX_W-1:0]   r_max,   n_max;
    logic [gis_pkg::CNT_W-1:0]   r_count, n_count;

    logic [gis_pkg::PIX_W-1:0]   r_lo,    n_lo;
    logic [gis_pkg::PIX_W-1:0]   r_hi,    n_hi;
    logic [gis_pkg::DIV_W-1:0]   r_rem,   n_rem;
    logic [gis_pkg::DIV_W-1:0]   r_dvs,   n_dvs;
    logic [gis_pkg::CON_Q_W-1:0] r_quo,   n_quo;
    logic [gis_pkg::STEP_W-1:0]  r_step,  n_step;
    logic [gis_pkg::PIX_W-1:0]   r_mean,  n_mean;
    logic                        r_undef, n_undef;

    logic                        r_out_valid, n_out_valid;
    logic [gis_pkg::PIX_W-1:0]   r_out_mean,  n_out_mean;
    logic [gis_pkg::PIX_W-1:0]   r_out_min,   n_out_min;
    logic [gis_pkg::PIX_W-1:0]   r_out_max,   n_out_max;
    logic [gis_pkg::CON_Q_W-1:0] r_out_con,   n_out_con;
    logic                        r_out_undef, n_out_undef;

    logic                         w_take;
    logic [gis_pkg::SUM_W-1:0]    w_sum;
    logic [gis_pkg::PIX_W-1:0]    w_min;
    logic [gis_pkg::PIX_W-1:0]    w_max;
    logic [gis_pkg::CNT_W-1:0]    w_count;
    logic [gis_pkg::CFG_W-1:0]    w_dim_w;
    logic [gis_pkg::CFG_W-1:0]    w_dim_h;
    logic [gis_pkg::FRAME_W-1:0]  w_frame;
    logic                         w_last;
    logic                         w_ge;
    logic [gis_pkg::DIV_W-1:0]    w_diff;
    logic [gis_pkg::CON_Q_W-1:0]  w_quo;
    logic [gis_pkg::DEN_W-1:0]    w_den;
    logic [gis_pkg::PIX_W-1:0]    w_span;

    // Accumulator update for an accepted pixel
    assign w_take  = i_pix.valid && (r_state == gis_pkg::ST_IDLE);
    assign w_sum   = r_sum + gis_pkg::SUM_W'(i_pix.pixel);
    assign w_min   = (i_pix.pixel < r_min) ? i_pix.pixel : r_min;
    assign w_max   = (i_pix.pixel > r_max) ? i_pix.pixel : r_max;
    assign w_count = r_count + gis_pkg::CNT_W'(1);

    // Frame size and end-of-frame detection
    assign w_dim_w = clamp_dim(r_width,  gis_pkg::MAX_WIDTH);
    assign w_dim_h = clamp_dim(r_height, gis_pkg::MAX_HEIGHT);
    assign w_frame = gis_pkg::FRAME_W'(w_dim_w) * gis_pkg::FRAME_W'(w_dim_h);
    assign w_last  = gis_pkg::CMP_W'(w_count) >= gis_pkg::CMP_W'(w_frame);

    // Shared restoring divider step
    assign w_ge   = r_rem >= r_dvs;
    assign w_diff = r_rem - r_dvs;
    assign w_quo  = {r_quo[gis_pkg::CON_Q_W-2:0], w_ge};

    // Contrast operands
    assign w_den  = gis_pkg::DEN_W'(r_hi) + gis_pkg::DEN_W'(r_lo);
    assign w_span = r_hi - r_lo;

    assign i_pix.ready              = (r_state == gis_pkg::ST_IDLE);
    assign o_res.valid              = r_out_valid;
    assign o_res.mean_level         = r_out_mean;
    assign o_res.min_level          = r_out_min;
    assign o_res.max_level          = r_out_max;
    assign o_res.contrast_q16       = r_out_con;
    assign o_res.contrast_undefined = r_out_undef;

    // Sequencer and next-state logic
    always_comb begin
        n_state     = r_state;
        n_width     = r_width;
        n_height    = r_height;
        n_sum       = r_sum;
        n_min       = r_min;
        n_max       = r_max;
        n_count     = r_count;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_rem       = r_rem;
        n_dvs       = r_dvs;
        n_quo       = r_quo;
        n_step      = r_step;
        n_mean      = r_mean;
        n_undef     = r_undef;
        n_out_valid = r_out_valid && !o_res.ready;
        n_out_mean  = r_out_mean;
        n_out_min   = r_out_min;
        n_out_max   = r_out_max;
        n_out_con   = r_out_con;
        n_out_undef = r_out_undef;

        // Configuration writes; unknown indexes are dropped
        if (i_cfg_we) begin
            case (i_cfg_idx)
                gis_pkg::CFG_IDX_WIDTH:  n_width  = i_cfg_data;
                gis_pkg::CFG_IDX_HEIGHT: n_height = i_cfg_data;
                default: ;
            endcase
        end

        case (r_state)
            gis_pkg::ST_IDLE: begin
                if (w_take) begin
                    if (w_last) begin
                        // Latch the frame, start the mean division, clear stats
                        n_lo    = w_min;
                        n_hi    = w_max;
                        n_rem   = gis_pkg::DIV_W'(w_sum);
                        n_dvs   = gis_pkg::DIV_W'(w_count) << (gis_pkg::PIX_W - 1);
                        n_quo   = '0;
                        n_step  = gis_pkg::STEP_W'(gis_pkg::PIX_W - 1);
                        n_sum   = '0;
                        n_min   = gis_pkg::PIX_FULL;
                        n_max   = '0;
                        n_count = '0;
                        n_state = gis_pkg::ST_MEAN;
                    end else begin
                        n_sum   = w_sum;
                        n_min   = w_min;
                        n_max   = w_max;
                        n_count = w_count;
                    end
                end
            end
            gis_pkg::ST_MEAN: begin
                n_rem  = w_ge ? w_diff : r_rem;
                n_dvs  = r_dvs >> 1;
                n_quo  = w_quo;
                n_step = r_step - gis_pkg::STEP_W'(1);
                if (r_step == '0) begin
                    n_mean = w_quo[gis_pkg::PIX_W-1:0];
                    n_quo  = '0;
                    if (w_den == '0) begin
                        // All-black frame: contrast left at zero, flagged
                        n_undef = 1'b1;
                        n_state = gis_pkg::ST_DONE;
                    end else begin
                        n_undef = 1'b0;
                        n_rem   = gis_pkg::DIV_W'(w_span) << gis_pkg::FRAC_W;
                        n_dvs   = gis_pkg::DIV_W'(w_den) << gis_pkg::FRAC_W;
                        n_step  = gis_pkg::STEP_W'(gis_pkg::CON_STEPS - 1);
                        n_state = gis_pkg::ST_CON;
                    end
                end
            end
            gis_pkg::ST_CON: begin
                n_rem  = w_ge ? w_diff : r_rem;
                n_dvs  = r_dvs >> 1;
                n_quo  = w_quo;
                n_step = r_step - gis_pkg::STEP_W'(1);
                if (r_step == '0) begin
                    n_state = gis_pkg::ST_DONE;
                end
            end
            gis_pkg::ST_DONE: begin
                // Load the result register once it is free
                if (!r_out_valid || o_res.ready) begin
                    n_out_valid = 1'b1;
                    n_out_mean  = r_mean;
                    n_out_min   = r_lo;
                    n_out_max   = r_hi;
                    n_out_con   = r_quo;
                    n_out_undef = r_undef;
                    n_state     = gis_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = gis_pkg::ST_IDLE;
            end
        endcase
    end

    // Control state with reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= gis_pkg::ST_IDLE;
            r_width     <= gis_pkg::CFG_W'(1);
            r_height    <= gis_pkg::CFG_W'(1);
            r_sum       <= '0;
            r_min       <= gis_pkg::PIX_FULL;
            r_max       <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_width     <= n_width;
            r_height    <= n_height;
            r_sum       <= n_sum;
            r_min       <= n_min;
            r_max       <= n_max;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // Divider and result payload
    always_ff @(posedge i_clk) begin
        r_lo        <= n_lo;
        r_hi        <= n_hi;
        r_rem       <= n_rem;
        r_dvs       <= n_dvs;
        r_quo       <= n_quo;
        r_step      <= n_step;
        r_mean      <= n_mean;
        r_undef     <= n_undef;
        r_out_mean  <= n_out_mean;
        r_out_min   <= n_out_min;
        r_out_max   <= n_out_max;
        r_out_con   <= n_out_con;
        r_out_undef <= n_out_undef;
    end

endmodule
